[rtl/core/wahbc_pkg.sv]
// Package for the WAH bitmap count accumulator.
// Holds the word types, item kind codes and default sizes; depends on nothing.
package wahbc_pkg;

   // Default sizes of the count store.
   localparam int MAX_POSITIONS_DEF = 8192;
   localparam int COUNT_BITS_DEF    = 16;

   // Fixed field widths.
   localparam int KIND_W  = 2;
   localparam int WORD_W  = 32;
   localparam int INDEX_W = 13;
   localparam int POS_W   = 14;
   localparam int CNT_W   = 16;
   localparam int GROUP_W = 30;
   localparam int SPAN_W  = 35;
   localparam int BITS_PER_WORD = 31;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

   // Register word index of the bitmap length register.
   localparam logic REG_BITMAP_LENGTH = 1'b0;
   localparam logic [POS_W-1:0] BITMAP_LENGTH_RST = 14'd7440;

   // One input word.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [WORD_W-1:0]  wah_word;
      logic [INDEX_W-1:0] index;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [POS_W-1:0] position;
      logic             full_res;
   } rsp_type;

   // Control from the sequencer to the update unit for one position.
   typedef struct packed {
      logic issue;
      logic hit;
   } bump_type;

endpackage

[rtl/core/wahbc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the count store; depends on nothing.
module wahbc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/wahbc_update.sv]
// Shared saturating increment unit: the write-back half of the count
// read-modify-write. Depends on wahbc_pkg.
module wahbc_update #(
   parameter int ADDR_W     = 13,
   parameter int COUNT_BITS = wahbc_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wahbc_pkg::bump_type    bump,
   input  logic [ADDR_W-1:0]      bump_addr,
   input  logic [COUNT_BITS-1:0]  rd_data,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [COUNT_BITS-1:0]  wr_data
);

   logic              hit_ff;
   logic              hit_in;
   logic [ADDR_W-1:0] addr_ff;

   // Track which read is returning and whether its position takes a bit.
   assign hit_in = bump.issue & bump.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= bump_addr;
   end

   // Increment the returned count, holding at the maximum.
   always_comb begin
      if (&rd_data) begin
         wr_data = rd_data;
      end else begin
         wr_data = rd_data + COUNT_BITS'(1);
      end
   end

   assign wr_en   = hit_ff;
   assign wr_addr = addr_ff;

endmodule

[rtl/core/wah_bitmap_count_accumulate.sv]
// Top level of the WAH bitmap count accumulator: sequencer, position state,
// register port and result register. Depends on wahbc_pkg, wahbc_ram, wahbc_update.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+---------------------------
//   input   | req_valid, req_stall, req_data          | one item word per handshake
//   result  | rsp_valid, rsp_stall, rsp_data          | one result word per item
//   config  | psel, penable, pwrite, paddr, pwdata... | bitmap length register
//
// A compressed word walks its positions: the bits of a literal or the positions of a one
// fill, both clipped at the bitmap length, one position per cycle through the single
// read-modify-write port of the count store. A zero fill or a word that places nothing
// walks no position; a read in range waits on the registered store output, an end of
// bitmap goes straight to its result, and a clear sweeps every position of the store.
// After reset the store is zeroed by a pass over every position with no item
// taken. The next item is taken while a result waits on a stalled output.
module wah_bitmap_count_accumulate #(
   parameter int MAX_POSITIONS = wahbc_pkg::MAX_POSITIONS_DEF,
   parameter int COUNT_BITS    = wahbc_pkg::COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wahbc_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wahbc_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int ADDR_W = $clog2(MAX_POSITIONS);
   localparam int POS_W  = wahbc_pkg::POS_W;
   localparam int SPAN_W = wahbc_pkg::SPAN_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_RDWAIT = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;
   localparam logic [2:0] ST_INIT   = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [POS_W-1:0]        len_ff;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [POS_W-1:0]        walk_ff, walk_in;
   logic [POS_W-1:0]        stop_ff, stop_in;
   logic [SPAN_W-1:0]       span_ff, span_in;
   logic [31:0]             word_ff, word_in;
   logic                    fill_ff, fill_in;
   logic                    one_ff, one_in;
   logic [15:0]             cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   wahbc_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                    req_take;
   logic                    rsp_load;
   logic                    cfg_write;
   logic [POS_W-1:0]        eff_len;
   logic [SPAN_W:0]         span_sum;
   logic [SPAN_W-1:0]       group_span;
   logic                    idx_ok;
   logic                    sweep;

   wahbc_pkg::bump_type     bump;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [COUNT_BITS-1:0]   ram_wdata;
   logic                    ram_re;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [COUNT_BITS-1:0]   ram_rdata;
   logic                    upd_we;
   logic [ADDR_W-1:0]       upd_waddr;
   logic [COUNT_BITS-1:0]   upd_wdata;

   // Register port: one register, decoded on the word address only.
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & (paddr[2] == wahbc_pkg::REG_BITMAP_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= wahbc_pkg::BITMAP_LENGTH_RST;
      end else if (cfg_write) begin
         len_ff <= pwdata[POS_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == wahbc_pkg::REG_BITMAP_LENGTH) begin
         prdata = 32'(len_ff);
      end else begin
         prdata = 32'd0;
      end
   end

   // Effective bitmap length is capped by the store depth.
   assign eff_len = (32'(len_ff) < MAX_POSITIONS) ? len_ff : POS_W'(MAX_POSITIONS);

   // Span of a fill word is 31 times its group count.
   assign group_span = (SPAN_W'(req_data.wah_word[wahbc_pkg::GROUP_W-1:0]) << 5)
                       - SPAN_W'(req_data.wah_word[wahbc_pkg::GROUP_W-1:0]);
   assign span_sum   = (SPAN_W+1)'(pos_ff) + (SPAN_W+1)'(span_ff);
   assign idx_ok     = 32'(req_data.index) < MAX_POSITIONS;

   // Handshakes.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign rsp_load  = (state_ff == ST_DONE) & (~rsp_valid_ff | ~rsp_stall);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      walk_in  = walk_ff;
      stop_in  = stop_ff;
      span_in  = span_ff;
      word_in  = word_ff;
      fill_in  = fill_ff;
      one_in   = one_ff;
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cnt_in  = 16'd0;
               word_in = req_data.wah_word;
               fill_in = req_data.wah_word[31];
               one_in  = req_data.wah_word[30];
               if (req_data.wah_word[31]) begin
                  span_in = group_span;
               end else begin
                  span_in = SPAN_W'(wahbc_pkg::BITS_PER_WORD);
               end
               unique case (req_data.kind)
                  wahbc_pkg::KIND_WORD: begin
                     state_in = ST_SETUP;
                  end
                  wahbc_pkg::KIND_END: begin
                     pos_in   = '0;
                     state_in = ST_DONE;
                  end
                  wahbc_pkg::KIND_READ: begin
                     state_in = idx_ok ? ST_RDWAIT : ST_DONE;
                  end
                  wahbc_pkg::KIND_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            // Clip the new position at the bitmap length; a word past the end
            // places nothing and leaves the position alone.
            if (pos_ff >= eff_len) begin
               state_in = ST_DONE;
            end else begin
               if (span_sum >= (SPAN_W+1)'(eff_len)) begin
                  stop_in = eff_len;
               end else begin
                  stop_in = POS_W'(span_sum);
               end
               pos_in  = stop_in;
               walk_in = pos_ff;
               if ((fill_ff & ~one_ff) || (stop_in == pos_ff)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // One position per cycle through the update unit.
            word_in = word_ff << 1;
            walk_in = walk_ff + POS_W'(1);
            if (walk_in == stop_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_RDWAIT: begin
            cnt_in   = 16'(ram_rdata);
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAX_POSITIONS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_INIT: begin
            // Zeroing pass after reset; it answers no item.
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAX_POSITIONS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         pos_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      stop_ff <= stop_in;
      span_ff <= span_in;
      word_ff <= word_in;
      fill_ff <= fill_in;
      one_ff  <= one_in;
      cnt_ff  <= cnt_in;
   end

   // Result register, parted from the sequencer so the next item can start.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.count    = cnt_ff;
         rsp_data_in.position = pos_ff;
         rsp_data_in.full_res = (pos_ff >= eff_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Count store ports: the clearing sweeps and the update unit share the write
   // port; the walk and count reads share the read port.
   assign sweep      = (state_ff == ST_CLEAR) | (state_ff == ST_INIT);
   assign bump.issue = (state_ff == ST_WALK);
   assign bump.hit   = fill_ff | word_ff[30];

   assign ram_re    = bump.issue | (req_take & (req_data.kind == wahbc_pkg::KIND_READ));
   assign ram_raddr = bump.issue ? ADDR_W'(walk_ff) : ADDR_W'(req_data.index);
   assign ram_we    = sweep | upd_we;
   assign ram_waddr = sweep ? clr_ff : upd_waddr;
   assign ram_wdata = sweep ? '0 : upd_wdata;

   wahbc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (MAX_POSITIONS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wahbc_update #(
      .ADDR_W     (ADDR_W),
      .COUNT_BITS (COUNT_BITS)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .bump      (bump),
      .bump_addr (ram_raddr),
      .rd_data   (ram_rdata),
      .wr_en     (upd_we),
      .wr_addr   (upd_waddr),
      .wr_data   (upd_wdata)
   );

`ifndef SYNTHESIS
   // The walk pointer never reaches the stop position while walking.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (walk_ff < stop_ff))
      else $error("walk pointer past stop position");

   // Outside the clearing sweeps every count written back is nonzero.
   a_nonzero_wb: assert property (@(posedge clock) disable iff (reset)
      (ram_we && !sweep) |-> (ram_wdata != '0))
      else $error("update unit wrote a zero count");

   // No write-back is still in flight when a count read returns.
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDWAIT) |-> !ram_we)
      else $error("store written during a count read");

   // A finished item shows up on the result channel in the next cycle.
   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid)
      else $error("finished item not presented");
`endif

endmodule

[bench/wah_bitmap_count_accumulate_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for wah_bitmap_count_accumulate: directed table, then random phases.
// Depends on wahbc_pkg and the block's RTL; predicts every result word in place.
module wah_bitmap_count_accumulate_test;
   import wahbc_pkg::*;

   localparam int          QUIET_LIMIT = 40000;  // outlasts a clear or a long fill
   localparam int          HOLD_CYCLES = 300;
   localparam logic [2:0]  LEN_ADDR    = {REG_BITMAP_LENGTH, 2'b00};

   // Block ports; every input starts at a known value.
   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [2:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   // Predicted state of the block.
   logic [CNT_W-1:0] tally [0:MAX_POSITIONS_DEF-1];
   logic [POS_W-1:0] fill_pos;
   logic [POS_W-1:0] bitmap_len;
   rsp_type          awaited[$];

   // Run control shared between processes.
   int unsigned tx_gap_pct   = 0;
   int unsigned rx_stall_pct = 0;
   bit          hold_wanted  = 1'b0;
   int unsigned errors       = 0;
   int unsigned n_items      = 0;
   int unsigned n_results    = 0;
   int unsigned n_clears     = 0;
   int unsigned n_settings   = 0;

   // One directed row: optional length write before it, the item, and a typed-in answer.
   typedef struct packed {
      logic             set_len;
      logic [POS_W-1:0] len;
      req_type          item;
      logic             typed;
      rsp_type          want;
   } probe_row_type;

   probe_row_type probes [0:23] = '{
      // Fresh store after reset reads zero at both ends.
      '{1'b0, 14'd0, '{KIND_READ, 32'h0000_0000, 13'd0},    1'b1, '{16'd0, 14'd0, 1'b0}},
      '{1'b0, 14'd0, '{KIND_READ, 32'h0000_0000, 13'd8191}, 1'b1, '{16'd0, 14'd0, 1'b0}},
      // Literals: all ones, all zeros, both end bits, alternating.
      '{1'b0, 14'd0, '{KIND_WORD, 32'h7FFF_FFFF, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_WORD, 32'h0000_0000, 13'd8191}, 1'b0, '0},
      '{1'b0, 14'd0, '{KIND_WORD, 32'h4000_0001, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_WORD, 32'h2AAA_AAAA, 13'd0},    1'b0, '0},
      // Fills with a zero group count place nothing and do not advance; a one fill and a zero fill follow.
      '{1'b0, 14'd0, '{KIND_WORD, 32'h8000_0000, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_WORD, 32'hC000_0000, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_WORD, 32'hC000_0002, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_WORD, 32'h8000_0001, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_READ, 32'h0000_0000, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_READ, 32'hFFFF_FFFF, 13'd124},  1'b0, '0},
      // Length lowered below the position: nothing placed, position kept.
      '{1'b1, 14'd100, '{KIND_WORD, 32'h7FFF_FFFF, 13'd0},  1'b0, '0},
      '{1'b0, 14'd0, '{KIND_READ, 32'h0000_0000, 13'd99},   1'b0, '0},
      '{1'b0, 14'd0, '{KIND_END,  32'h0000_0000, 13'd0},    1'b1, '{16'd0, 14'd0, 1'b0}},
      // Widest length register; a maximal one fill overruns to the store's end.
      '{1'b1, 14'd16383, '{KIND_WORD, 32'hFFFF_FFFF, 13'd0}, 1'b0, '0},
      '{1'b0, 14'd0, '{KIND_READ, 32'h0000_0000, 13'd8191}, 1'b0, '0},
      '{1'b0, 14'd0, '{KIND_END,  32'h0000_0000, 13'd0},    1'b0, '0},
      '{1'b0, 14'd0, '{KIND_WORD, 32'hBFFF_FFFF, 13'd0},    1'b1, '{16'd0, 14'd8192, 1'b1}},
      // Zero length drops every bit and reads as full.
      '{1'b1, 14'd0, '{KIND_END,  32'h0000_0000, 13'd0},    1'b1, '{16'd0, 14'd0, 1'b1}},
      '{1'b0, 14'd0, '{KIND_WORD, 32'h7FFF_FFFF, 13'd0},    1'b1, '{16'd0, 14'd0, 1'b1}},
      // Clear empties the store.
      '{1'b1, 14'd7440, '{KIND_CLEAR, 32'h0000_0000, 13'd0}, 1'b1, '{16'd0, 14'd0, 1'b0}},
      '{1'b0, 14'd0, '{KIND_READ, 32'h0000_0000, 13'd0},    1'b1, '{16'd0, 14'd0, 1'b0}},
      '{1'b0, 14'd0, '{KIND_READ, 32'h0000_0000, 13'd8191}, 1'b1, '{16'd0, 14'd0, 1'b0}}
   };

   wah_bitmap_count_accumulate dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Expands one item into positions, bumps the counts and forms its result word.
   task automatic expand_and_tally(input req_type w, output rsp_type r);
      int unsigned       lim;
      int unsigned       p;
      int unsigned       k;
      longint unsigned   span;
      longint unsigned   reach;
      lim = (bitmap_len > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF : bitmap_len;
      r = '0;
      case (w.kind)
         KIND_WORD: begin
            if (!w.wah_word[31]) begin
               // Literal: bit 30 lands on the current position.
               for (k = 0; k < BITS_PER_WORD; k++) begin
                  p = fill_pos + k;
                  if (p < lim && w.wah_word[30-k] && tally[p] != '1)
                     tally[p] = tally[p] + 1'b1;
               end
               span = BITS_PER_WORD;
            end else begin
               span = 64'(w.wah_word[GROUP_W-1:0]);
               span = span * BITS_PER_WORD;
               if (w.wah_word[30]) begin
                  reach = fill_pos + span;
                  for (p = fill_pos; p < lim && p < reach; p++)
                     if (tally[p] != '1) tally[p] = tally[p] + 1'b1;
               end
            end
            // The position stops at the length and never moves once there.
            if (fill_pos < lim) begin
               reach = fill_pos + span;
               fill_pos = (reach >= lim) ? POS_W'(lim) : POS_W'(reach);
            end
         end
         KIND_END: fill_pos = '0;
         KIND_READ: r.count = tally[w.index];
         default: begin
            for (p = 0; p < MAX_POSITIONS_DEF; p++) tally[p] = '0;
         end
      endcase
      r.position = fill_pos;
      r.full_res = (fill_pos >= lim);
   endtask

   // Offers one word after an optional gap and records its expected result once taken.
   task automatic send_item(input req_type w, input logic typed, input rsp_type want);
      rsp_type calc;
      if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      expand_and_tally(w, calc);
      awaited.push_back(typed ? want : calc);
      n_items++;
      if (w.kind == KIND_CLEAR) n_clears++;
   endtask

   // Waits until the block is idle, then writes the length register and reads it back.
   task automatic set_bitmap_length(input logic [POS_W-1:0] v);
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= LEN_ADDR;
      pwdata  <= {{(32-POS_W){1'b0}}, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[POS_W-1:0] !== v) begin
         $error("bitmap_length readback: expected %0d, got %0d", v, prdata[POS_W-1:0]);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      bitmap_len = v;
      n_settings++;
   endtask

   // Compares one accepted result word with the oldest expectation.
   task automatic compare_tally(input rsp_type got);
      rsp_type want;
      n_results++;
      if (awaited.size() == 0) begin
         $error("result word with no item outstanding: %h", got);
         errors++;
         return;
      end
      want = awaited.pop_front();
      if (got.count !== want.count) begin
         $error("count: expected %0d, got %0d", want.count, got.count);
         errors++;
      end
      if (got.position !== want.position) begin
         $error("position: expected %0d, got %0d", want.position, got.position);
         errors++;
      end
      if (got.full_res !== want.full_res) begin
         $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
         errors++;
      end
   endtask

   // Result side: checks accepted words and stalls in bursts, plus one long hold-off.
   initial begin : result_sink
      int unsigned burst;
      int unsigned hold_left;
      bit          hold_done;
      burst     = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) compare_tally(rsp_data);
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst != 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            burst = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Ends the run when neither channel moves a word for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Main sequence: reset, directed table, then random phases over several lengths.
   initial begin : stimulus
      req_type          w;
      int unsigned      lim;
      int unsigned      roll;
      int unsigned      pick;
      int unsigned      n_phase;
      logic [POS_W-1:0] len;
      for (int i = 0; i < MAX_POSITIONS_DEF; i++) tally[i] = '0;
      fill_pos   = '0;
      bitmap_len = BITMAP_LENGTH_RST;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      tx_gap_pct   = 20;
      rx_stall_pct = 20;
      foreach (probes[i]) begin
         if (probes[i].set_len) set_bitmap_length(probes[i].len);
         send_item(probes[i].item, probes[i].typed, probes[i].want);
      end

      // Random phases; the last runs with no idling on either side.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin len = 14'd31;    n_phase = 200; tx_gap_pct = 25; rx_stall_pct = 0;  end
            1: begin len = 14'd2000;  n_phase = 200; tx_gap_pct = 10; rx_stall_pct = 30; end
            2: begin len = 14'd1;     n_phase = 200; tx_gap_pct = 40; rx_stall_pct = 10; end
            3: begin len = 14'd0;     n_phase = 40;  tx_gap_pct = 0;  rx_stall_pct = 40; end
            4: begin len = 14'd8192;  n_phase = 200; tx_gap_pct = 25; rx_stall_pct = 25; end
            5: begin
               len = POS_W'($urandom_range(2, 8191));
               n_phase = 200; tx_gap_pct = 0; rx_stall_pct = 40;
            end
            6: begin len = 14'd16383; n_phase = 200; tx_gap_pct = 40; rx_stall_pct = 10; end
            default: begin
               len = BITMAP_LENGTH_RST; n_phase = 220; tx_gap_pct = 0; rx_stall_pct = 0;
            end
         endcase
         set_bitmap_length(len);
         // The result side holds off once here while words keep coming in.
         if (ph == 1) hold_wanted = 1'b1;
         lim = (len > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF : len;
         for (int n = 0; n < n_phase; n++) begin
            roll = $urandom_range(0, 999);
            // Fields the kind ignores are left random so every bit toggles.
            w.wah_word = $urandom;
            w.index    = INDEX_W'($urandom);
            if (roll < 820) begin
               w.kind = KIND_WORD;
               if ($urandom_range(0, 99) < 55) begin
                  w.wah_word[31] = 1'b0;
               end else begin
                  w.wah_word[31] = 1'b1;
                  pick = $urandom_range(0, 99);
                  if (pick < 85)
                     w.wah_word[GROUP_W-1:0] = GROUP_W'($urandom_range(0, 6));
                  else if (pick < 95)
                     w.wah_word[GROUP_W-1:0] = GROUP_W'($urandom_range(7, 60));
                  // Otherwise the random group count runs to the end of the bitmap.
               end
            end else if (roll < 900) begin
               w.kind = KIND_READ;
               if (lim != 0 && $urandom_range(0, 9) < 7)
                  w.index = INDEX_W'($urandom_range(0, lim - 1));
            end else if (roll < 990) begin
               w.kind = KIND_END;
            end else begin
               w.kind = KIND_CLEAR;
            end
            send_item(w, 1'b0, '0);
         end
      end

      // Let the last results come out, then let the clock run on before the summary.
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run sent %0d item words and checked %0d result words, including %0d clears,",
               n_items, n_results, n_clears);
      $display("over %0d bitmap length settings from 0 up to the widest register value.",
               n_settings);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
